/* rtl/eqbq_pkg.sv */
// ----------------------------------------------------------------------------
// eqbq_pkg
// Shared types and constants of the stereo biquad cascade equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package eqbq_pkg;

    localparam int NUM_BANDS_DEF  = 5;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int COEFS_PER_BAND = 5;
    localparam int SAMPLE_W       = 32;
    localparam int CFG_IDX_W      = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_FLAT = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_COEF   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        TERM_B0 = 3'd0,
        TERM_B1 = 3'd1,
        TERM_B2 = 3'd2,
        TERM_A1 = 3'd3,
        TERM_A2 = 3'd4
    } t_term;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MAC,
        SEQ_DONE
    } t_seq_state;

    typedef struct packed {
        t_kind                      kind;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic        [2:0]          band_index;
        logic        [2:0]          coef_select;
        logic signed [SAMPLE_W-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_item;

    // sequencer to lane control
    typedef struct packed {
        logic  load;
        logic  clear;
        logic  issue;
        t_term term;
        logic  accum;
        logic  first;
        logic  commit;
    } t_lane_ctrl;

endpackage

`default_nettype wire

/* rtl/eqbq_coef.sv */
// ----------------------------------------------------------------------------
// eqbq_coef
// Coefficient store: five Q-format words per band, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module eqbq_coef #(
    parameter int NUM_BANDS = eqbq_pkg::NUM_BANDS_DEF,
    parameter int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [BAND_W-1:0]                     i_wr_band,
    input  wire eqbq_pkg::t_term                       i_wr_term,
    input  wire logic signed [eqbq_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  wire logic [BAND_W-1:0]                     i_rd_band,
    input  wire eqbq_pkg::t_term                       i_rd_term,
    output logic signed [eqbq_pkg::SAMPLE_W-1:0]       o_rd_data
);

    logic signed [eqbq_pkg::SAMPLE_W-1:0]
        r_coef [NUM_BANDS][eqbq_pkg::COEFS_PER_BAND];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_coef[i_wr_band][i_wr_term] <= i_wr_data;
        end
    end

    assign o_rd_data = r_coef[i_rd_band][i_rd_term];

endmodule

`default_nettype wire

/* rtl/eqbq_lane.sv */
// ----------------------------------------------------------------------------
// eqbq_lane
// One channel: biquad history for every band and a shared multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module eqbq_lane #(
    parameter int NUM_BANDS = eqbq_pkg::NUM_BANDS_DEF,
    parameter int FRAC_BITS = eqbq_pkg::FRAC_BITS_DEF,
    parameter int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire eqbq_pkg::t_lane_ctrl                  i_ctrl,
    input  wire logic [BAND_W-1:0]                     i_band,
    input  wire logic signed [eqbq_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic signed [eqbq_pkg::SAMPLE_W-1:0]  i_coef,
    output logic signed [eqbq_pkg::SAMPLE_W-1:0]       o_value
);

    localparam int W = eqbq_pkg::SAMPLE_W;

    logic signed [W-1:0]   r_x1 [NUM_BANDS];
    logic signed [W-1:0]   r_x2 [NUM_BANDS];
    logic signed [W-1:0]   r_y1 [NUM_BANDS];
    logic signed [W-1:0]   r_y2 [NUM_BANDS];
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_acc;
    logic signed [2*W-1:0] r_prod;
    logic                  r_sub;

    logic signed [W-1:0]   operand;
    logic signed [W-1:0]   term_val;
    logic signed [W-1:0]   acc_base;
    logic signed [W-1:0]   n_acc;

    always_comb begin
        case (i_ctrl.term)
            eqbq_pkg::TERM_B0: operand = r_x;
            eqbq_pkg::TERM_B1: operand = r_x1[i_band];
            eqbq_pkg::TERM_B2: operand = r_x2[i_band];
            eqbq_pkg::TERM_A1: operand = r_y1[i_band];
            eqbq_pkg::TERM_A2: operand = r_y2[i_band];
            default:           operand = r_x;
        endcase
    end

    // floor shift of the product; the low word of the sum is all that survives the wrap
    assign term_val = r_prod[FRAC_BITS+W-1:FRAC_BITS];
    assign acc_base = i_ctrl.first ? '0 : r_acc;
    assign n_acc    = r_sub ? (acc_base - term_val) : (acc_base + term_val);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= (2*W)'(i_coef) * (2*W)'(operand);
            r_sub  <= (i_ctrl.term == eqbq_pkg::TERM_A1) ||
                      (i_ctrl.term == eqbq_pkg::TERM_A2);
        end
        if (i_ctrl.accum) begin
            r_acc <= n_acc;
        end
        if (i_ctrl.load) begin
            r_x <= i_sample;
        end else if (i_ctrl.commit) begin
            r_x <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                r_x1[b] <= '0;
                r_x2[b] <= '0;
                r_y1[b] <= '0;
                r_y2[b] <= '0;
            end
        end else if (i_ctrl.commit) begin
            r_x2[i_band] <= r_x1[i_band];
            r_x1[i_band] <= r_x;
            r_y2[i_band] <= r_y1[i_band];
            r_y1[i_band] <= n_acc;
        end
    end

    assign o_value = r_x;

endmodule

`default_nettype wire

/* rtl/eqbq_seq.sv */
// ----------------------------------------------------------------------------
// eqbq_seq
// Sequencer: steps both lanes through bands and terms and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module eqbq_seq #(
    parameter int NUM_BANDS = eqbq_pkg::NUM_BANDS_DEF,
    parameter int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_filter,
    input  wire logic                  i_clear,
    input  wire logic                  i_out_free,
    output logic                       o_idle,
    output logic                       o_emit,
    output logic [BAND_W-1:0]          o_band,
    output eqbq_pkg::t_lane_ctrl       o_ctrl
);

    localparam logic [2:0] STEP_DRAIN = 3'(eqbq_pkg::COEFS_PER_BAND);
    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

    eqbq_pkg::t_seq_state r_state, n_state;
    logic [BAND_W-1:0]    r_band, n_band;
    logic [2:0]           r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eqbq_pkg::SEQ_IDLE;
            r_band  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        n_step  = r_step;
        o_idle  = 1'b0;
        o_emit  = 1'b0;
        o_ctrl  = '0;
        o_ctrl.term = eqbq_pkg::TERM_B0;
        unique case (r_state)
            eqbq_pkg::SEQ_IDLE: begin
                o_idle       = 1'b1;
                o_ctrl.clear = i_clear;
                o_ctrl.load  = i_start;
                n_band       = '0;
                n_step       = '0;
                if (i_start) begin
                    n_state = i_filter ? eqbq_pkg::SEQ_MAC : eqbq_pkg::SEQ_DONE;
                end
            end
            eqbq_pkg::SEQ_MAC: begin
                // one product issued per step, accumulated one step later
                o_ctrl.issue = (r_step != STEP_DRAIN);
                o_ctrl.term  = (r_step != STEP_DRAIN) ? eqbq_pkg::t_term'(r_step)
                                                      : eqbq_pkg::TERM_B0;
                o_ctrl.accum = (r_step != '0);
                o_ctrl.first = (r_step == 3'd1);
                o_ctrl.commit = (r_step == STEP_DRAIN);
                if (r_step == STEP_DRAIN) begin
                    n_step = '0;
                    if (r_band == LAST_BAND) begin
                        n_state = eqbq_pkg::SEQ_DONE;
                    end else begin
                        n_band = r_band + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            eqbq_pkg::SEQ_DONE: begin
                o_emit = i_out_free;
                if (i_out_free) begin
                    n_state = eqbq_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_state = eqbq_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign o_band = r_band;

endmodule

`default_nettype wire

/* rtl/stereo_biquad_cascade_equalizer.sv */
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_equalizer
// Stereo cascade of direct-form-I biquads with Q-format coefficients.
// ----------------------------------------------------------------------------
//   i_in carries one item per beat (i_in_valid / o_in_ready): a stereo sample,
//   a coefficient write or a history clear. A sample beat gives one beat on
//   o_out (o_out_valid / i_out_ready); the other kinds give nothing.
//   i_cfg_* writes the enabled and all_flat registers; the user must do so
//   only while idle, as the block does not enforce it. Coefficient writes
//   and clears keep the block idle. A filtered sample runs five products
//   per band through one 32x32 multiplier per channel plus a drain step,
//   band by band, then waits for the output register; a bypassed sample
//   goes straight to that wait. Left and right run in two lanes at once
//   and share one coefficient read. One item is in work at a time; the
//   next is taken once the result sits in the output register, so a
//   stalled receiver holds at most one result and one finished item.
//   Reset sets enabled and all_flat, zeroes all history and empties the
//   output; coefficients hold garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_cascade_equalizer #(
    parameter int NUM_BANDS = eqbq_pkg::NUM_BANDS_DEF,
    parameter int FRAC_BITS = eqbq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire eqbq_pkg::t_in_item                 i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output eqbq_pkg::t_out_item                     o_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [eqbq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic                               i_cfg_data
);

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    logic                 r_enabled;
    logic                 r_all_flat;
    logic                 r_out_valid;
    eqbq_pkg::t_out_item  r_out;

    logic                 idle;
    logic                 emit;
    logic                 in_beat;
    logic                 start;
    logic                 clear;
    logic                 coef_wr;
    logic                 out_free;
    logic [BAND_W-1:0]    band;
    eqbq_pkg::t_lane_ctrl ctrl;
    logic signed [eqbq_pkg::SAMPLE_W-1:0] coef;
    logic signed [eqbq_pkg::SAMPLE_W-1:0] left_val;
    logic signed [eqbq_pkg::SAMPLE_W-1:0] right_val;

    assign o_in_ready  = idle;
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_in_valid && idle;
    assign start       = in_beat && (i_in.kind == eqbq_pkg::KIND_SAMPLE);
    assign clear       = in_beat && (i_in.kind == eqbq_pkg::KIND_CLEAR);
    assign coef_wr     = in_beat && (i_in.kind == eqbq_pkg::KIND_COEF) &&
                         (32'(i_in.band_index) < 32'(NUM_BANDS)) &&
                         (32'(i_in.coef_select) < 32'(eqbq_pkg::COEFS_PER_BAND));
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b1;
            r_all_flat <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                eqbq_pkg::CFG_ENABLED:  r_enabled  <= i_cfg_data;
                eqbq_pkg::CFG_ALL_FLAT: r_all_flat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    eqbq_coef #(
        .NUM_BANDS (NUM_BANDS),
        .BAND_W    (BAND_W)
    ) u_coef (
        .i_clk     (i_clk),
        .i_wr_en   (coef_wr),
        .i_wr_band (BAND_W'(i_in.band_index)),
        .i_wr_term (eqbq_pkg::t_term'(i_in.coef_select)),
        .i_wr_data (i_in.coef_value),
        .i_rd_band (band),
        .i_rd_term (ctrl.term),
        .o_rd_data (coef)
    );

    eqbq_seq #(
        .NUM_BANDS (NUM_BANDS),
        .BAND_W    (BAND_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_filter   (r_enabled && !r_all_flat),
        .i_clear    (clear),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_emit     (emit),
        .o_band     (band),
        .o_ctrl     (ctrl)
    );

    eqbq_lane #(
        .NUM_BANDS (NUM_BANDS),
        .FRAC_BITS (FRAC_BITS),
        .BAND_W    (BAND_W)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_band   (band),
        .i_sample (i_in.left_sample),
        .i_coef   (coef),
        .o_value  (left_val)
    );

    eqbq_lane #(
        .NUM_BANDS (NUM_BANDS),
        .FRAC_BITS (FRAC_BITS),
        .BAND_W    (BAND_W)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_band   (band),
        .i_sample (i_in.right_sample),
        .i_coef   (coef),
        .o_value  (right_val)
    );

    // merge both lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.left_out  <= left_val;
            r_out.right_out <= right_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
